// ===== design/assert_macros.svh =====
// assertion macros for the rtl files, included by tblc_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/tblc_pkg.sv =====
// types and constants of the translated block lookup cache
`default_nettype none
package tblc_pkg;

    localparam int CACHE_BITS_DEF = 10;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_FILL   = 2'd1;
    localparam logic [1:0] REQ_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] guest_address;
        logic [31:0] fill_index;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] block_index;
    } t_rsp;

    typedef struct packed {
        logic [63:0] tag;
        logic [31:0] index;
    } t_entry;

    typedef struct packed {
        logic sweep_start;
        logic clear_wr;
        logic fill_wr;
        logic lookup_rd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic sweep_done;
    } t_sts;

endpackage
`default_nettype wire

// ===== design/translated_block_lookup_cache_unit.sv =====
// top level of the translated block lookup cache
`default_nettype none
// Direct-mapped cache from a 64-bit guest address to a 32-bit translated block
// index, 2^CACHE_BITS slots in one single-port entry memory. A lookup request
// reads the entry memory at the edge that takes it. Its response is loaded into
// the response register in ST_LOOK once that register is free and is offered
// from the cycle after. The next request is taken at the same edge that can
// collect that response, so a new lookup is not taken until the last one has
// loaded its response. A stalled response holds the next lookup until the
// response is taken. A fill is taken without a stall and the next request may
// follow at once; a fill with a zero index and the unused request code do
// nothing. A flush, and reset, start a clearing pass that writes one slot per
// cycle over all 2^CACHE_BITS slots (1024 at the default), during which
// o_in_stall stays high. Only lookups produce a response.
module translated_block_lookup_cache_unit #(
    parameter int CACHE_BITS = tblc_pkg::CACHE_BITS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  tblc_pkg::t_req   i_in_req,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output tblc_pkg::t_rsp   o_out_rsp
);
    import tblc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tblc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req       (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    tblc_datapath #(
        .CACHE_BITS (CACHE_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_out_rsp)
    );

endmodule
`default_nettype wire

// ===== design/tblc_datapath.sv =====
// slot hash, entry memory, clear sweep counter and response register
`default_nettype none
module tblc_datapath #(
    parameter int CACHE_BITS = tblc_pkg::CACHE_BITS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  tblc_pkg::t_req   i_req,
    input  tblc_pkg::t_cmd   i_cmd,
    output tblc_pkg::t_sts   o_sts,
    output tblc_pkg::t_rsp   o_rsp
);
    import tblc_pkg::*;

    localparam int SLOTS = 1 << CACHE_BITS;

    t_entry                r_mem [SLOTS];
    t_entry                r_rd_data;
    logic [63:0]           r_addr;
    logic [CACHE_BITS-1:0] r_sweep_cnt;
    logic [CACHE_BITS-1:0] n_sweep_cnt;
    t_rsp                  r_rsp;

    logic [CACHE_BITS-1:0] slot_in;
    logic [CACHE_BITS-1:0] wr_slot;
    t_entry                wr_data;
    logic                  wr_en;
    logic                  hit;

    // fold the address bits just above the slot field onto it
    assign slot_in = i_req.guest_address[CACHE_BITS-1:0]
                   ^ i_req.guest_address[2*CACHE_BITS-1:CACHE_BITS];

    always_comb begin
        wr_en   = i_cmd.clear_wr || i_cmd.fill_wr;
        wr_slot = slot_in;
        wr_data = '{tag: i_req.guest_address, index: i_req.fill_index};
        if (i_cmd.clear_wr) begin
            wr_slot = r_sweep_cnt;
            wr_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_slot] <= wr_data;
        end
        if (i_cmd.lookup_rd) begin
            r_rd_data <= r_mem[slot_in];
        end
    end

    always_comb begin
        n_sweep_cnt = r_sweep_cnt;
        if (i_cmd.sweep_start) begin
            n_sweep_cnt = '0;
        end else if (i_cmd.clear_wr) begin
            n_sweep_cnt = r_sweep_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_cnt <= '0;
        end else begin
            r_sweep_cnt <= n_sweep_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup_rd) begin
            r_addr <= i_req.guest_address;
        end
    end

    assign hit = (r_rd_data.tag == r_addr) && (r_rd_data.index != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_rsp.hit         <= hit;
            r_rsp.block_index <= hit ? r_rd_data.index : '0;
        end
    end

    assign o_sts.sweep_done = &r_sweep_cnt;
    assign o_rsp            = r_rsp;

endmodule
`default_nettype wire

// ===== design/tblc_ctrl.sv =====
// controller: clear sweep, request decode and response handshake
`default_nettype none
`include "assert_macros.svh"
module tblc_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  tblc_pkg::t_req   i_req,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output tblc_pkg::t_cmd   o_cmd,
    input  tblc_pkg::t_sts   i_sts
);
    import tblc_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_acc;
    logic       out_free;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.sweep_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_req.req_type)
                        REQ_LOOKUP: begin
                            o_cmd.lookup_rd = 1'b1;
                            n_state = ST_LOOK;
                        end
                        REQ_FILL: begin
                            // a zero index leaves the slot alone
                            o_cmd.fill_wr = (i_req.fill_index != '0);
                        end
                        REQ_FLUSH: begin
                            o_cmd.sweep_start = 1'b1;
                            n_state = ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOOK: begin
                // wait for the response register to free up
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `ASSERT_ALWAYS(a_no_overwrite, i_clk, i_rst_n, !(o_cmd.out_load && r_out_valid && i_out_stall))
    `ASSERT_NEXT(a_taken_drops, i_clk, i_rst_n, r_out_valid && !i_out_stall && !o_cmd.out_load, !r_out_valid)
    `ASSERT_NEXT(a_lookup_reads, i_clk, i_rst_n, in_acc && (i_req.req_type == REQ_LOOKUP), r_state == ST_LOOK)
    `ASSERT_NEXT(a_flush_sweeps, i_clk, i_rst_n, in_acc && (i_req.req_type == REQ_FLUSH), r_state == ST_CLEAR)

endmodule
`default_nettype wire
